@@ design/tsc_pkg.sv @@
// shared types and constants of the token scanner
package tsc_pkg;

  typedef enum logic [3:0] {
    TOK_RETURN = 4'd0,
    TOK_IF     = 4'd1,
    TOK_IDENT  = 4'd2,
    TOK_LPAREN = 4'd3,
    TOK_RPAREN = 4'd4,
    TOK_LBRACE = 4'd5,
    TOK_RBRACE = 4'd6,
    TOK_OP     = 4'd7,
    TOK_SEMI   = 4'd8,
    TOK_NUMBER = 4'd9,
    TOK_FIN    = 4'd10,
    TOK_ERROR  = 4'd11
  } tok_type_t;

  localparam int LEN_WIDTH     = 16;
  localparam int OUT_OFF_WIDTH = 32;
  localparam int OUT_POS_WIDTH = 16;

  typedef struct packed {
    tok_type_t                 token_type;
    logic [OUT_OFF_WIDTH-1:0]  start_offset;
    logic [LEN_WIDTH-1:0]      token_length;
    logic [OUT_POS_WIDTH-1:0]  start_row;
    logic [OUT_POS_WIDTH-1:0]  start_col;
    logic [7:0]                first_char;
    logic                      end_of_run;
  } tok_t;

  // up to two results written into the result queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    tok_t       r0;
    tok_t       r1;
  } tok_push_t;

endpackage

@@ design/tsc_in_if.sv @@
// character channel: one byte or an end-of-text marker per transfer
interface tsc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ch;

  modport source (output valid, op, ch, input ready);
  modport sink (input valid, op, ch, output ready);
endinterface

@@ design/tsc_out_if.sv @@
// token channel: one token description per transfer
interface tsc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_type;
  logic [31:0] start_offset;
  logic [15:0] token_length;
  logic [15:0] start_row;
  logic [15:0] start_col;
  logic [7:0]  first_char;
  logic        end_of_run;

  modport source (output valid, token_type, start_offset, token_length, start_row,
                  start_col, first_char, end_of_run, input ready);
  modport sink (input valid, token_type, start_offset, token_length, start_row,
                start_col, first_char, end_of_run, output ready);
endinterface

@@ design/tsc_queue.sv @@
// four-entry result queue, takes up to two tokens per cycle and gives one
module tsc_queue (
  input  logic               clk,
  input  logic               rst,
  input  tsc_pkg::tok_push_t push,
  input  logic               pop,
  output logic               room2,
  output logic               head_valid,
  output tsc_pkg::tok_t      head
);
  import tsc_pkg::*;

  tok_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [1:0] wr_ptr_p1;
  logic       do_pop;

  assign wr_ptr_p1  = wr_ptr + 2'd1;
  assign head_valid = (count != 3'd0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;
  // room check on the registered count keeps the output ready out of the input ready path
  assign room2      = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      if (do_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(push.count) - 3'(do_pop);
    end
  end
endmodule

@@ design/token_scanner.sv @@
// token scanner top level: input register, scan logic, result queue
//
//   channel  dir  payload                                   transfer
//   src      in   op, ch                                    valid & ready
//   tok      out  token_type, start_offset, token_length,   valid & ready
//                 start_row, start_col, first_char, end_of_run
//
// one character per cycle while the queue has room: each byte is scanned from the
// input register, and the up to two tokens it yields enter a four-entry result queue.
// the queue drains one token per cycle while the output is ready, so bytes that end a
// run and emit a symbol at once need two output transfers.
// synchronous reset clears the scan state and empties the queue.
// a stalled output fills the queue; input stalls once fewer than two slots are free.
module token_scanner #(
  parameter int OFFSET_WIDTH   = 32,
  parameter int POSITION_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  tsc_in_if.sink    src,
  tsc_out_if.source tok
);
  import tsc_pkg::*;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_IDENT  = 2'd1,
    KIND_NUMBER = 2'd2
  } kind_t;

  localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
  localparam logic [LEN_WIDTH-1:0]      LEN_MAX = '1;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_STAR   = 8'h2a;

  function automatic logic [7:0] return_char(input logic [2:0] i);
    case (i)
      3'd0:    return 8'h72;
      3'd1:    return 8'h65;
      3'd2:    return 8'h74;
      3'd3:    return 8'h75;
      3'd4:    return 8'h72;
      default: return 8'h6e;
    endcase
  endfunction

  function automatic tok_type_t symbol_type(input logic [7:0] c);
    case (c)
      CH_LPAREN:               return TOK_LPAREN;
      CH_RPAREN:               return TOK_RPAREN;
      CH_LBRACE:               return TOK_LBRACE;
      CH_RBRACE:               return TOK_RBRACE;
      CH_SEMI:                 return TOK_SEMI;
      CH_LT, CH_MINUS, CH_STAR: return TOK_OP;
      default:                 return TOK_ERROR;
    endcase
  endfunction

  function automatic logic [OUT_POS_WIDTH-1:0] sat_pos(input logic [POSITION_WIDTH-1:0] v);
    if ((v >> OUT_POS_WIDTH) != '0) begin
      return '1;
    end
    return OUT_POS_WIDTH'(v);
  endfunction

  // input register
  logic       held;
  logic       h_op;
  logic [7:0] h_ch;
  logic       fire;
  logic       q_room;

  // scan state
  kind_t                     pending_kind, pending_kind_next;
  logic [OFFSET_WIDTH-1:0]   token_start, token_start_next;
  logic [LEN_WIDTH-1:0]      token_len, token_len_next;
  logic [POSITION_WIDTH-1:0] token_row, token_row_next;
  logic [POSITION_WIDTH-1:0] token_column, token_column_next;
  logic [7:0]                token_first, token_first_next;
  logic [1:0]                keyword_viable, keyword_viable_next;
  logic [OFFSET_WIDTH-1:0]   cur_offset, cur_offset_next;
  logic [POSITION_WIDTH-1:0] cur_row, cur_row_next;
  logic [POSITION_WIDTH-1:0] cur_col, cur_col_next;

  logic      is_letter, is_digit, is_sep, cont, flush_v, sec_v;
  logic      ret_hit, if_hit;
  logic [1:0] kv_add;
  logic [LEN_WIDTH-1:0] len_add;
  tok_type_t flush_type;
  tok_t      flush_r, sec_r;
  tok_push_t push;
  tok_t      head;
  logic      head_valid;

  assign fire      = held && q_room;
  assign src.ready = !held || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (src.ready) begin
      held <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      h_op <= src.op;
      h_ch <= src.ch;
    end
  end

  // byte classes
  assign is_letter = (h_ch >= 8'h61 && h_ch <= 8'h7a) || (h_ch >= 8'h41 && h_ch <= 8'h5a)
                     || h_ch == CH_UNDER;
  assign is_digit  = (h_ch >= 8'h30 && h_ch <= 8'h39);
  assign is_sep    = (h_ch == CH_SPACE) || (h_ch == CH_TAB) || (h_ch == CH_NL);
  assign cont      = !h_op && ((pending_kind == KIND_IDENT && is_letter)
                               || (pending_kind == KIND_NUMBER && is_digit));
  assign flush_v   = (pending_kind != KIND_NONE) && !cont;
  assign sec_v     = h_op || (!is_sep && !is_letter && !is_digit);

  // incremental keyword match on the byte that extends the run
  assign ret_hit = (token_len < LEN_WIDTH'(6)) && (return_char(token_len[2:0]) == h_ch);
  assign if_hit  = (token_len < LEN_WIDTH'(2))
                   && (h_ch == (token_len[0] ? 8'h66 : 8'h69));
  assign kv_add  = {keyword_viable[1] && if_hit, keyword_viable[0] && ret_hit};
  assign len_add = (token_len == LEN_MAX) ? token_len : token_len + LEN_WIDTH'(1);

  always_comb begin
    if (pending_kind == KIND_NUMBER) begin
      flush_type = TOK_NUMBER;
    end else if (keyword_viable[0] && token_len == LEN_WIDTH'(6)) begin
      flush_type = TOK_RETURN;
    end else if (keyword_viable[1] && token_len == LEN_WIDTH'(2)) begin
      flush_type = TOK_IF;
    end else begin
      flush_type = TOK_IDENT;
    end
  end

  always_comb begin
    flush_r.token_type   = flush_type;
    flush_r.start_offset = OUT_OFF_WIDTH'(token_start);
    flush_r.token_length = token_len;
    flush_r.start_row    = sat_pos(token_row);
    flush_r.start_col    = sat_pos(token_column);
    flush_r.first_char   = token_first;
    flush_r.end_of_run   = !sec_v;

    sec_r.start_offset = OUT_OFF_WIDTH'(cur_offset);
    sec_r.start_row    = sat_pos(cur_row);
    sec_r.start_col    = sat_pos(cur_col);
    sec_r.end_of_run   = 1'b1;
    if (h_op) begin
      sec_r.token_type   = TOK_FIN;
      sec_r.token_length = '0;
      sec_r.first_char   = 8'h00;
    end else begin
      sec_r.token_type   = symbol_type(h_ch);
      sec_r.token_length = LEN_WIDTH'(1);
      sec_r.first_char   = h_ch;
    end

    push.r1 = sec_r;
    push.r0 = flush_v ? flush_r : sec_r;
    if (!fire) begin
      push.count = 2'd0;
    end else begin
      push.count = 2'(flush_v) + 2'(sec_v);
    end
  end

  always_comb begin
    pending_kind_next   = pending_kind;
    token_start_next    = token_start;
    token_len_next      = token_len;
    token_row_next      = token_row;
    token_column_next   = token_column;
    token_first_next    = token_first;
    keyword_viable_next = keyword_viable;
    cur_offset_next     = cur_offset + OFFSET_WIDTH'(1);
    cur_row_next        = cur_row;
    cur_col_next        = cur_col;

    if (h_ch == CH_NL) begin
      if (cur_row != POS_MAX) begin
        cur_row_next = cur_row + POS_ONE;
      end
      cur_col_next = POS_ONE;
    end else if (cur_col != POS_MAX) begin
      cur_col_next = cur_col + POS_ONE;
    end

    if (h_op) begin
      // end of text: back to the reset state
      pending_kind_next   = KIND_NONE;
      token_start_next    = '0;
      token_len_next      = '0;
      token_row_next      = POS_ONE;
      token_column_next   = POS_ONE;
      token_first_next    = 8'h00;
      keyword_viable_next = 2'b11;
      cur_offset_next     = '0;
      cur_row_next        = POS_ONE;
      cur_col_next        = POS_ONE;
    end else if (cont) begin
      token_len_next      = len_add;
      keyword_viable_next = kv_add;
    end else if (is_letter || is_digit) begin
      pending_kind_next   = is_letter ? KIND_IDENT : KIND_NUMBER;
      token_start_next    = cur_offset;
      token_len_next      = LEN_WIDTH'(1);
      token_row_next      = cur_row;
      token_column_next   = cur_col;
      token_first_next    = h_ch;
      keyword_viable_next = {h_ch == 8'h69, h_ch == 8'h72};
    end else begin
      pending_kind_next = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_kind   <= KIND_NONE;
      token_start    <= '0;
      token_len      <= '0;
      token_row      <= POS_ONE;
      token_column   <= POS_ONE;
      token_first    <= 8'h00;
      keyword_viable <= 2'b11;
      cur_offset     <= '0;
      cur_row        <= POS_ONE;
      cur_col        <= POS_ONE;
    end else if (fire) begin
      pending_kind   <= pending_kind_next;
      token_start    <= token_start_next;
      token_len      <= token_len_next;
      token_row      <= token_row_next;
      token_column   <= token_column_next;
      token_first    <= token_first_next;
      keyword_viable <= keyword_viable_next;
      cur_offset     <= cur_offset_next;
      cur_row        <= cur_row_next;
      cur_col        <= cur_col_next;
    end
  end

  tsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (tok.ready),
    .room2      (q_room),
    .head_valid (head_valid),
    .head       (head)
  );

  assign tok.valid        = head_valid;
  assign tok.token_type   = head.token_type;
  assign tok.start_offset = head.start_offset;
  assign tok.token_length = head.token_length;
  assign tok.start_row    = head.start_row;
  assign tok.start_col    = head.start_col;
  assign tok.first_char   = head.first_char;
  assign tok.end_of_run   = head.end_of_run;
endmodule

@@ design/tsc_checker.sv @@
// port-level assertions for the token scanner and their bind
module tsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        tok_valid,
  input logic        tok_ready,
  input logic [3:0]  token_type,
  input logic [15:0] token_length,
  input logic [7:0]  first_char,
  input logic        end_of_run
);
  import tsc_pkg::*;

  // fin closes the run and carries no text
  a_fin_shape: assert property (@(posedge clk) disable iff (rst)
    tok_valid && token_type == TOK_FIN |-> end_of_run && token_length == 16'd0
                                            && first_char == 8'h00)
    else $error("fin token malformed");

  // single-character tokens are always the last of their byte
  a_symbol_shape: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (token_type == TOK_LPAREN || token_type == TOK_RPAREN
                  || token_type == TOK_LBRACE || token_type == TOK_RBRACE
                  || token_type == TOK_OP || token_type == TOK_SEMI
                  || token_type == TOK_ERROR)
    |-> token_length == 16'd1 && end_of_run)
    else $error("symbol token malformed");

  a_keyword_len: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (token_type == TOK_RETURN || token_type == TOK_IF)
    |-> (token_type == TOK_RETURN && token_length == 16'd6)
        || (token_type == TOK_IF && token_length == 16'd2))
    else $error("keyword length wrong");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(token_type)
                                && $stable(token_length) && $stable(end_of_run))
    else $error("stalled token changed");
endmodule

bind token_scanner tsc_checker u_tsc_checker (
  .clk          (clk),
  .rst          (rst),
  .tok_valid    (tok.valid),
  .tok_ready    (tok.ready),
  .token_type   (tok.token_type),
  .token_length (tok.token_length),
  .first_char   (tok.first_char),
  .end_of_run   (tok.end_of_run)
);
